// ----- src/mse_pkg.sv -----
// types and constants shared by the merge sort engine
package mse_pkg;

  localparam int unsigned KEY_W = 32;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic             final_item;
  } in_word_t;

  typedef struct packed {
    logic [KEY_W-1:0] sorted_key;
    logic             run_end;
  } out_word_t;

endpackage

// ----- src/merge_sort_engine.sv -----
// merge sort engine: buffers a set of keys, sorts it with ping-pong memories, emits it in order
//
//  channel  | signals                       | word
//  ---------+-------------------------------+----------------------------------
//  input    | in_valid, in_ready, in_data   | key, final_item
//  output   | out_valid, out_ready, out_data| sorted_key, run_end
//
// a set of n keys is loaded word by word, then sorted in one merge pass for each
// doubling of the run width below n (ceil(log2 n) passes), each led by S_PRIME; a last
// S_PRIME starts the emit, which returns to loading once the last word has been taken.
// each merge pass writes one word a cycle to the write port of the destination memory.
// sync reset clears control only, memories are not cleared.
// in_ready is high only while loading; the emit side holds its word until taken.
module merge_sort_engine
  import mse_pkg::*;
#(
  parameter int unsigned CAPACITY = 64,
  parameter int unsigned KEY_BITS = 32
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_word_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_word_t out_data
);

  localparam int unsigned SB = (KEY_BITS < KEY_W) ? KEY_BITS : KEY_W;
  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned CW = AW + 1;
  localparam int unsigned XW = AW + 2;

  typedef enum logic [1:0] {
    S_LOAD,
    S_PRIME,
    S_MERGE,
    S_EMIT
  } state_t;

  state_t state_r, state_nxt;
  logic [CW-1:0] fill_r, fill_nxt;
  logic [CW-1:0] n_r, n_nxt;
  logic [CW-1:0] w_r, w_nxt;
  logic          sel_r, sel_nxt;
  logic [CW-1:0] i_r, i_nxt;
  logic [CW-1:0] j_r, j_nxt;
  logic [CW-1:0] mid_r, mid_nxt;
  logic [CW-1:0] hi_r, hi_nxt;
  logic [CW-1:0] k_r, k_nxt;
  logic          out_valid_r, out_valid_nxt;
  out_word_t     out_data_r, out_data_nxt;

  logic [SB-1:0] mem0 [CAPACITY];
  logic [SB-1:0] mem1 [CAPACITY];
  logic [SB-1:0] rd0_left_r, rd0_right_r, rd1_left_r, rd1_right_r;
  logic [SB-1:0] q_left, q_right;
  logic [AW-1:0] addr_left, addr_right;
  logic          wr0_en, wr1_en;
  logic [AW-1:0] wr_addr;
  logic [SB-1:0] wr_data;
  logic          take_l;

  function automatic logic [CW-1:0] clamp_n(input logic [XW-1:0] x, input logic [CW-1:0] n);
    clamp_n = (x > XW'(n)) ? n : x[CW-1:0];
  endfunction

  function automatic logic [AW-1:0] mem_addr(input logic [CW-1:0] x);
    mem_addr = (x < CW'(CAPACITY)) ? x[AW-1:0] : '0;
  endfunction

  assign q_left  = sel_r ? rd1_left_r : rd0_left_r;
  assign q_right = sel_r ? rd1_right_r : rd0_right_r;
  // equal keys: right run goes first
  assign take_l = (i_r < mid_r) && ((j_r >= hi_r) || (q_left < q_right));

  assign addr_left  = mem_addr(i_nxt);
  assign addr_right = mem_addr(j_nxt);

  always_comb begin
    state_nxt     = state_r;
    fill_nxt      = fill_r;
    n_nxt         = n_r;
    w_nxt         = w_r;
    sel_nxt       = sel_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    mid_nxt       = mid_r;
    hi_nxt        = hi_r;
    k_nxt         = k_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    wr0_en        = 1'b0;
    wr1_en        = 1'b0;
    wr_addr       = fill_r[AW-1:0];
    wr_data       = in_data.key[SB-1:0];

    case (state_r)
      S_LOAD: begin
        if (in_valid) begin
          wr0_en   = 1'b1;
          fill_nxt = fill_r + 1'b1;
          if (in_data.final_item || (fill_r == CW'(CAPACITY - 1))) begin
            n_nxt     = fill_r + 1'b1;
            w_nxt     = CW'(1);
            sel_nxt   = 1'b0;
            state_nxt = S_PRIME;
          end
        end
      end
      S_PRIME: begin
        // memories written last cycle are safe to read from here
        i_nxt = '0;
        k_nxt = '0;
        if (w_r < n_r) begin
          mid_nxt   = clamp_n(XW'(w_r), n_r);
          j_nxt     = mid_nxt;
          hi_nxt    = clamp_n(XW'(w_r) << 1, n_r);
          state_nxt = S_MERGE;
        end else begin
          state_nxt = S_EMIT;
        end
      end
      S_MERGE: begin
        wr_addr = k_r[AW-1:0];
        wr_data = take_l ? q_left : q_right;
        wr0_en  = sel_r;
        wr1_en  = !sel_r;
        k_nxt   = k_r + 1'b1;
        if (take_l) begin
          i_nxt = i_r + 1'b1;
        end else begin
          j_nxt = j_r + 1'b1;
        end
        if (k_nxt == hi_r) begin
          if (hi_r == n_r) begin
            // pass done, swap source and destination
            w_nxt     = w_r << 1;
            sel_nxt   = !sel_r;
            state_nxt = S_PRIME;
          end else begin
            i_nxt   = hi_r;
            mid_nxt = clamp_n(XW'(hi_r) + XW'(w_r), n_r);
            j_nxt   = mid_nxt;
            hi_nxt  = clamp_n(XW'(hi_r) + (XW'(w_r) << 1), n_r);
          end
        end
      end
      S_EMIT: begin
        if (!out_valid_r || out_ready) begin
          if (i_r < n_r) begin
            out_valid_nxt           = 1'b1;
            out_data_nxt.sorted_key = KEY_W'(q_left);
            out_data_nxt.run_end    = (i_r == n_r - 1'b1);
            i_nxt                   = i_r + 1'b1;
          end else begin
            out_valid_nxt = 1'b0;
            fill_nxt      = '0;
            state_nxt     = S_LOAD;
          end
        end
      end
      default: begin
        state_nxt = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_LOAD;
      fill_r      <= '0;
      n_r         <= '0;
      w_r         <= '0;
      sel_r       <= 1'b0;
      i_r         <= '0;
      j_r         <= '0;
      mid_r       <= '0;
      hi_r        <= '0;
      k_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      n_r         <= n_nxt;
      w_r         <= w_nxt;
      sel_r       <= sel_nxt;
      i_r         <= i_nxt;
      j_r         <= j_nxt;
      mid_r       <= mid_nxt;
      hi_r        <= hi_nxt;
      k_r         <= k_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  // two read ports and one write port per memory
  always_ff @(posedge clk) begin
    if (wr0_en) begin
      mem0[wr_addr] <= wr_data;
    end
    rd0_left_r  <= mem0[addr_left];
    rd0_right_r <= mem0[addr_right];
  end

  always_ff @(posedge clk) begin
    if (wr1_en) begin
      mem1[wr_addr] <= wr_data;
    end
    rd1_left_r  <= mem1[addr_left];
    rd1_right_r <= mem1[addr_right];
  end

  assign in_ready  = (state_r == S_LOAD);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ----- tb/mse_checker.sv -----
// scoreboard for the merge sort engine: rebuilds each key set, sorts it and checks the output
module mse_checker
  import mse_pkg::*;
#(
  parameter int unsigned CAPACITY = 64,
  parameter int unsigned KEY_BITS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  in_word_t    in_data,
  input  logic        out_valid,
  input  logic        out_ready,
  input  out_word_t   out_data,
  output int unsigned err_count,
  output int unsigned pending,
  output int unsigned words_checked,
  output int unsigned sets_sorted
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [KEY_W-1:0] KEY_MASK = (KEY_BITS >= KEY_W) ? {KEY_W{1'b1}} :
                                          {KEY_W{1'b1}} >> (KEY_W - KEY_BITS);

  logic [KEY_W-1:0] set_keys [CAPACITY];
  logic [KEY_W-1:0] merge_buf [CAPACITY];
  int unsigned      set_len;
  out_word_t        sorted_q [$];

  always @(posedge clk) begin : watch
    int unsigned width, lo, mid, hi, i, j, k;
    out_word_t   want;
    if (!rst_n) begin
      set_len = 0;
      sorted_q.delete();
    end else begin
      if (in_valid && in_ready) begin
        set_keys[set_len] = in_data.key & KEY_MASK;
        set_len++;
        // a word that fills the buffer closes the set as if marked last
        if (in_data.final_item || set_len == CAPACITY) begin
          for (width = 1; width < set_len; width = width * 2) begin
            for (lo = 0; lo + width < set_len; lo = lo + 2 * width) begin
              mid = lo + width;
              hi = (mid + width > set_len) ? set_len : mid + width;
              i = lo;
              j = mid;
              // equal keys: the right run goes first
              for (k = lo; k < hi; k++) begin
                if (j >= hi || (i < mid && set_keys[i] < set_keys[j])) begin
                  merge_buf[k] = set_keys[i];
                  i++;
                end else begin
                  merge_buf[k] = set_keys[j];
                  j++;
                end
              end
              for (k = lo; k < hi; k++) set_keys[k] = merge_buf[k];
            end
          end
          for (k = 0; k < set_len; k++) begin
            want.sorted_key = set_keys[k];
            want.run_end = (k + 1 == set_len);
            sorted_q.push_back(want);
          end
          sets_sorted++;
          set_len = 0;
        end
      end
      if (out_valid && out_ready) begin
        if (sorted_q.size() == 0) begin
          err_count++;
          $display("%0t: unexpected output word: got key %h end %b", $time,
                   out_data.sorted_key, out_data.run_end);
        end else begin
          want = sorted_q.pop_front();
          if (out_data.sorted_key !== want.sorted_key || out_data.run_end !== want.run_end) begin
            err_count++;
            $display("%0t: output word %0d mismatch: expected key %h end %b, got key %h end %b",
                     $time, words_checked, want.sorted_key, want.run_end,
                     out_data.sorted_key, out_data.run_end);
          end
        end
        words_checked++;
      end
    end
    pending = sorted_q.size();
  end

endmodule

// ----- tb/tb_merge_sort_engine.sv -----
// top of the merge sort engine testbench: clock, reset, stimulus, watchdog and verdict
module tb_merge_sort_engine;
  timeunit 1ns;
  timeprecision 1ps;
  import mse_pkg::*;

  localparam int unsigned CAPACITY     = 64;
  localparam int unsigned KEY_BITS     = 32;
  localparam int unsigned PHASE_ITEMS  = 118;
  localparam int unsigned STALL_LIMIT  = 4000;
  localparam int unsigned DRAIN_CYCLES = 40;

  logic        clk       = 1'b0;
  logic        rst_n     = 1'b0;
  logic        in_valid  = 1'b0;
  logic        in_ready;
  in_word_t    in_data   = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_word_t   out_data;

  int unsigned err_count, pending, words_checked, sets_sorted;
  int unsigned send_idle_pct = 10;
  int unsigned recv_idle_pct = 69;
  int unsigned keys_sent     = 0;
  int unsigned stall_cycles  = 0;

  merge_sort_engine #(
    .CAPACITY (CAPACITY),
    .KEY_BITS (KEY_BITS)
  ) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  mse_checker #(
    .CAPACITY (CAPACITY),
    .KEY_BITS (KEY_BITS)
  ) i_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_data       (in_data),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_data      (out_data),
    .err_count     (err_count),
    .pending       (pending),
    .words_checked (words_checked),
    .sets_sorted   (sets_sorted)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // nothing accepted on either side for too long means the block has hung
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("%0t: watchdog expired, %0d output words still expected", $time, pending);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  function automatic logic [KEY_W-1:0] random_key();
    logic [KEY_W-1:0] key;
    case ($urandom_range(9))
      0, 1, 2, 3, 4: key = $urandom;
      5, 6:          key = $urandom_range(7);             // plenty of duplicates
      7:             key = $urandom_range(1) ? '1 : '0;
      default:       key = $urandom | 32'hFFFF_0000;
    endcase
    return key;
  endfunction

  task automatic send_key(input logic [KEY_W-1:0] key, input logic last);
    in_word_t word;
    word.key = key;
    word.final_item = last;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= word;
    do @(posedge clk); while (!in_ready);
    keys_sent++;
  endtask

  initial begin : stimulus
    int unsigned phase, n, set_size, phase_start;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // single-key sets at both extremes
    send_key('0, 1'b1);
    send_key('1, 1'b1);
    // reversed pair
    send_key('1, 1'b0);
    send_key('0, 1'b1);
    // alternating and single-bit patterns
    send_key(32'h5555_5555, 1'b0);
    send_key(32'hAAAA_AAAA, 1'b0);
    send_key(32'h0000_0001, 1'b0);
    send_key(32'h8000_0000, 1'b0);
    send_key(32'h7FFF_FFFF, 1'b1);
    // equal keys spread over both runs of each merge
    send_key(32'd7, 1'b0);
    send_key(32'd3, 1'b0);
    send_key(32'd7, 1'b0);
    send_key(32'd3, 1'b0);
    send_key(32'd7, 1'b0);
    send_key(32'd7, 1'b1);
    // already ascending, then descending
    for (n = 0; n < 5; n++) send_key(n * 32'h1111_1111, n == 4);
    for (n = 0; n < 5; n++) send_key(32'hF000_0000 - n * 32'h0100_0001, n == 4);

    for (phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 10;
          recv_idle_pct = 69;
        end
        1: begin
          send_idle_pct = 69;
          recv_idle_pct = 10;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      phase_start = keys_sent;
      // one large set per phase: last word on the full buffer, no last word at all
      // (cut by capacity), and an overrun whose tail forms a set of its own
      set_size = (phase == 2) ? CAPACITY + 6 : CAPACITY;
      for (n = 1; n <= set_size; n++) send_key(random_key(), phase != 1 && n == set_size);
      while (keys_sent - phase_start < PHASE_ITEMS) begin
        set_size = $urandom_range(12, 1);
        for (n = 1; n <= set_size; n++) send_key(random_key(), n == set_size);
      end
    end
    in_valid <= 1'b0;

    do @(negedge clk); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("run covered %0d keys in %0d sorted sets, %0d output words checked,", keys_sent,
             sets_sorted, words_checked);
    $display("including single keys, duplicates, a full buffer and capacity cut-offs");
    if (err_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
